### rtl/wera_pkg.sv
// Shared types and constants for the windowed event rate alarm.
package wera_pkg;

  // Fixed field widths
  localparam int EVENT_W = 32;
  localparam int SKIP_W  = 8;
  localparam int WIN_W   = 16;
  localparam int THR_W   = 5;
  localparam int HELD_W  = 5;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_THRESHOLD = 2'd2;

  // Reset values of the configuration registers
  localparam logic [SKIP_W-1:0] SKIP_RESET = 8'd1;
  localparam logic [WIN_W-1:0]  WIN_RESET  = 16'd10;
  localparam logic [THR_W-1:0]  THR_RESET  = 5'd3;

  // Cell operations
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD  = 2'd0;
  localparam cell_op_t OP_MARK  = 2'd1;
  localparam cell_op_t OP_SHIFT = 2'd2;
  localparam cell_op_t OP_LOAD  = 2'd3;

  // Command from the controller to one cell
  typedef struct packed {
    cell_op_t op;
    logic     live;
    logic     load;
  } cell_cmd_t;

endpackage

### rtl/wera_cell.sv
// One window cell: holds one stored time and its drop mark.
module wera_cell
  import wera_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_cmd_t            cmd,
  input  logic [TIME_BITS-1:0] now,
  input  logic [WIN_W-1:0]     window,
  input  logic                 hole_in,
  input  logic [TIME_BITS-1:0] next_time,
  input  logic                 next_drop,
  output logic [TIME_BITS-1:0] time_q,
  output logic                 drop_q,
  output logic                 expired,
  output logic                 hole_out
);

  logic [TIME_BITS-1:0] age;

  // Flag an entry older than the window; a later entry is kept
  assign age      = now - time_q;
  assign expired  = cmd.live && (now > time_q) && (age > TIME_BITS'(window));
  assign hole_out = hole_in | drop_q;

  // Hold the drop mark
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_q <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_MARK:  drop_q <= expired;
        OP_SHIFT: if (hole_out) drop_q <= next_drop;
        default:  drop_q <= drop_q;
      endcase
    end
  end

  // Hold, shift down or load the stored time
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_SHIFT: if (hole_out) time_q <= next_time;
      OP_LOAD:  if (cmd.load) time_q <= now;
      default:  time_q <= time_q;
    endcase
  end

endmodule

### rtl/windowed_event_rate_alarm.sv
// Top level of the windowed event rate alarm: controller and row of window cells.
//
// Input channel: event_time words, accepted when in_valid is high and
// in_stall is low. Output channel: one word per event (alarm, alarm_time,
// held_events), taken when out_valid is high and out_stall is low.
// Configuration: cfg_write with cfg_index/cfg_data writes one register per
// cycle (0 skip_count, 1 window_seconds, 2 alarm_threshold).
// Stored times sit in a row of cells ordered oldest first. An event that is
// skipped, fills an empty window or repeats the newest time finishes in the
// check state, which loads its result word once the output slot is free. An
// event that is appended marks expired cells, closes one gap per cycle by
// shifting the cells above it down, then appends and checks the alarm, its
// result word loaded in the alarm state once the output slot is free. One
// event is in work at a time. Reset clears the window, the event counter
// and the output valid flag, and loads the register defaults. While the
// receiver stalls, the finished word is held; a following event is still
// taken and worked on up to the point where its own result word is due.
module windowed_event_rate_alarm
  import wera_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16,
  parameter int TIME_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [EVENT_W-1:0]   event_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 alarm,
  output logic [EVENT_W-1:0]   alarm_time,
  output logic [HELD_W-1:0]    held_events
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (OCC_W > THR_W) ? OCC_W : THR_W;
  localparam int TW    = (TIME_BITS > EVENT_W) ? TIME_BITS : EVENT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_COMPACT = 3'd2;
  localparam logic [2:0] S_APPEND  = 3'd3;
  localparam logic [2:0] S_ALARM   = 3'd4;

  // Registers
  logic [2:0]           state, state_next;
  logic [OCC_W-1:0]     occ, occ_next;
  logic [SKIP_W-1:0]    counter, counter_next;
  logic [TIME_BITS-1:0] now_q;
  logic [SKIP_W-1:0]    skip_count;
  logic [WIN_W-1:0]     window_seconds;
  logic [THR_W-1:0]     alarm_threshold;

  // Controller signals
  cell_op_t                cell_op;
  logic                    hole_first;
  logic [WINDOW_DEPTH-1:0] load_sel;
  logic [WINDOW_DEPTH-1:0] live;
  logic                    res_load;
  logic                    res_alarm;
  logic [EVENT_W-1:0]      res_time;
  logic [HELD_W-1:0]       res_held;
  logic                    slot_free;
  logic                    skip_hit, empty_hit, dup_hit, fire;
  logic [OCC_W-1:0]        drop_count;
  logic [OCC_W-1:0]        rd_full;
  logic [IDX_W-1:0]        rd_idx;
  logic [TIME_BITS-1:0]    rd_time;
  logic [TW-1:0]           ev_wide, rd_wide;
  logic [TIME_BITS-1:0]    now_in;

  // Cell row wiring
  logic [TIME_BITS-1:0]    cell_time [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_drop;
  logic [WINDOW_DEPTH-1:0] cell_exp;
  logic [WINDOW_DEPTH:0]   hole;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Cut or widen the event time to the stored width
  assign ev_wide = TW'(event_time);
  assign now_in  = ev_wide[TIME_BITS-1:0];

  // Single read point into the row: newest entry, or middle entry on alarm
  assign rd_full = (state == S_ALARM) ? (occ >> 1) : (occ - 1'b1);
  assign rd_idx  = rd_full[IDX_W-1:0];
  assign rd_time = cell_time[rd_idx];
  assign rd_wide = TW'(rd_time);

  assign drop_count = OCC_W'($countones(cell_exp));
  assign skip_hit   = counter < skip_count;
  assign empty_hit  = !skip_hit && (occ == '0);
  assign dup_hit    = !skip_hit && !empty_hit && (rd_time == now_q);
  assign fire       = CMP_W'(occ) >= CMP_W'(alarm_threshold);

  // Decode live cells
  always_comb begin
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      live[k] = OCC_W'(k) < occ;
    end
  end

  // Sequence one event through check and, if appended, compaction, append, alarm
  always_comb begin
    state_next   = state;
    occ_next     = occ;
    counter_next = counter;
    cell_op      = OP_HOLD;
    hole_first   = 1'b0;
    load_sel     = '0;
    res_load     = 1'b0;
    res_alarm    = 1'b0;
    res_time     = '0;
    res_held     = HELD_W'(occ);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          counter_next = (counter == '1) ? counter : counter + 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (skip_hit || empty_hit || dup_hit) begin
          if (slot_free) begin
            res_load   = 1'b1;
            state_next = S_IDLE;
            if (empty_hit) begin
              cell_op     = OP_LOAD;
              load_sel[0] = 1'b1;
              occ_next    = OCC_W'(1);
              res_held    = HELD_W'(1);
            end
          end
        end else begin
          cell_op    = OP_MARK;
          occ_next   = occ - drop_count;
          state_next = S_COMPACT;
        end
      end
      S_COMPACT: begin
        if (|cell_drop) begin
          cell_op = OP_SHIFT;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        if (occ == OCC_W'(WINDOW_DEPTH)) begin
          cell_op    = OP_SHIFT;
          hole_first = 1'b1;
        end else begin
          cell_op  = OP_LOAD;
          occ_next = occ + 1'b1;
          for (int k = 0; k < WINDOW_DEPTH; k++) begin
            load_sel[k] = (occ == OCC_W'(k));
          end
        end
        state_next = S_ALARM;
      end
      S_ALARM: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (fire) begin
            res_alarm    = 1'b1;
            res_time     = rd_wide[EVENT_W-1:0];
            res_held     = '0;
            occ_next     = '0;
            counter_next = '0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      counter <= '0;
    end else begin
      state   <= state_next;
      occ     <= occ_next;
      counter <= counter_next;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) now_q <= now_in;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count      <= SKIP_RESET;
      window_seconds  <= WIN_RESET;
      alarm_threshold <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SKIP_COUNT:      skip_count      <= cfg_data[SKIP_W-1:0];
        REG_WINDOW_SECONDS:  window_seconds  <= cfg_data[WIN_W-1:0];
        REG_ALARM_THRESHOLD: alarm_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      alarm       <= res_alarm;
      alarm_time  <= res_time;
      held_events <= res_held;
    end
  end

  // Row of cells, oldest entry at cell zero
  assign hole[0] = hole_first;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    cell_cmd_t            cmd;
    logic [TIME_BITS-1:0] nxt_time;
    logic                 nxt_drop;

    assign cmd = '{op: cell_op, live: live[k], load: load_sel[k]};

    if (k == WINDOW_DEPTH - 1) begin : g_top
      assign nxt_time = now_q;
      assign nxt_drop = 1'b0;
    end else begin : g_mid
      assign nxt_time = cell_time[k+1];
      assign nxt_drop = cell_drop[k+1];
    end

    wera_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .now       (now_q),
      .window    (window_seconds),
      .hole_in   (hole[k]),
      .next_time (nxt_time),
      .next_drop (nxt_drop),
      .time_q    (cell_time[k]),
      .drop_q    (cell_drop[k]),
      .expired   (cell_exp[k]),
      .hole_out  (hole[k+1])
    );
  end

endmodule

### rtl/wera_checker.sv
// Port-level checks for the windowed event rate alarm, bound to the top level.
module wera_checker
  import wera_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 alarm,
  input logic [EVENT_W-1:0]   alarm_time,
  input logic [HELD_W-1:0]    held_events
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alarm_time)
      && $stable(alarm) && $stable(held_events))
    else $error("stalled result word changed");

  // Drop the time when no alarm is raised
  a_quiet_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && !alarm |-> alarm_time == '0)
    else $error("alarm_time nonzero without alarm");

  // Empty the window on alarm
  a_alarm_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm |-> held_events == '0)
    else $error("window not cleared on alarm");

  // Busy in the cycle after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted back to back");

  // No result word right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind windowed_event_rate_alarm wera_checker u_wera_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .alarm       (alarm),
  .alarm_time  (alarm_time),
  .held_events (held_events)
);
